// ----- design/pslt_pkg.sv -----
// Shared types and constants for the plane side test and line intersect block.
// Holds the request and result payload structs and the divider cell record.
// No dependencies.
package pslt_pkg;

    // Fraction bits of the plane normal.
    localparam int NORM_FRAC = 14;
    // Width of the signed distance and denominator sums.
    localparam int DW = 50;
    // Width of the distance and denominator magnitudes.
    localparam int MW = 48;
    // Quotient bits produced by the divider chain.
    localparam int QBITS = 33;

    // Request modes.
    localparam logic [1:0] MODE_POINT  = 2'd0;
    localparam logic [1:0] MODE_SPHERE = 2'd1;
    localparam logic [1:0] MODE_LINE   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NORMAL_X = 2'd0;
    localparam logic [1:0] CFG_NORMAL_Y = 2'd1;
    localparam logic [1:0] CFG_NORMAL_Z = 2'd2;
    localparam logic [1:0] CFG_OFFSET   = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [30:0]        radius;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } pslt_in_t;

    typedef struct packed {
        logic               in_front;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic               parallel;
        logic               clipped;
    } pslt_out_t;

    // Record handed from one divider cell to the next; three lanes, one per axis.
    typedef struct packed {
        logic [2:0][MW-1:0]    rem;
        logic [2:0][QBITS-1:0] num;
        logic [2:0][QBITS-1:0] quo;
        logic [MW-1:0]         den;
        logic [2:0][31:0]      pnt;
        logic [2:0]            pos;
        logic [2:0]            ovf;
        logic [1:0]            mode;
        logic                  in_front;
        logic                  par;
    } pslt_cell_t;

endpackage

// ----- design/pslt_cell.sv -----
// One restoring division step for all three axes, with its own pipeline register.
// Depends on pslt_pkg.
module pslt_cell
    import pslt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  pslt_cell_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pslt_cell_t out_data
);

    logic       valid_reg;
    pslt_cell_t data_reg;
    pslt_cell_t data_next;
    logic [MW:0] rem2 [3];
    logic [2:0]  ge;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Shift in the next numerator bit and subtract the divisor where it fits.
    always_comb begin
        data_next = in_data;
        for (int l = 0; l < 3; l++) begin
            rem2[l] = {in_data.rem[l], in_data.num[l][QBITS-1]};
            ge[l]   = rem2[l] >= {1'b0, in_data.den};
            if (ge[l]) begin
                data_next.rem[l] = MW'(rem2[l] - {1'b0, in_data.den});
            end else begin
                data_next.rem[l] = rem2[l][MW-1:0];
            end
            data_next.num[l] = {in_data.num[l][QBITS-2:0], 1'b0};
            data_next.quo[l] = {in_data.quo[l][QBITS-2:0], ge[l]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- design/pslt_front.sv -----
// Front pipeline: dot products, distance and denominator sums, side tests,
// numerator products and the first divider record. Depends on pslt_pkg.
module pslt_front
    import pslt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [15:0] nx,
    input  logic signed [15:0] ny,
    input  logic signed [15:0] nz,
    input  logic signed [31:0] offset,
    input  logic               s_valid,
    output logic               s_ready,
    input  pslt_in_t           s_payload,
    output logic               out_valid,
    input  logic               out_ready,
    output pslt_cell_t         out_data
);

    // Stage A: products of the normal with point and direction.
    logic               a_valid_reg;
    logic [1:0]         a_mode_reg;
    logic signed [31:0] a_p_reg [3];
    logic signed [31:0] a_v_reg [3];
    logic [30:0]        a_rad_reg;
    logic signed [31:0] a_off_reg;
    logic signed [47:0] a_np_reg [3];
    logic signed [47:0] a_nv_reg [3];
    logic               a_ready;

    // Stage B: sums.
    logic               b_valid_reg;
    logic [1:0]         b_mode_reg;
    logic signed [31:0] b_p_reg [3];
    logic signed [31:0] b_v_reg [3];
    logic [30:0]        b_rad_reg;
    logic signed [DW-1:0] b_dist_reg;
    logic signed [DW-1:0] b_den_reg;
    logic signed [DW-1:0] b_dist_next;
    logic signed [DW-1:0] b_den_next;
    logic               b_ready;

    // Stage C: side tests, magnitudes and split numerator products.
    logic               c_valid_reg;
    logic [1:0]         c_mode_reg;
    logic [2:0][31:0]   c_p_reg;
    logic               c_front_reg;
    logic               c_par_reg;
    logic [MW-1:0]      c_den_reg;
    logic [2:0]         c_pos_reg;
    logic [63:0]        c_plo_reg [3];
    logic [47:0]        c_phi_reg [3];
    logic               c_front_next;
    logic [MW-1:0]      c_dmag_next;
    logic [MW-1:0]      c_den_next;
    logic [31:0]        c_vmag_next [3];
    logic [32:0]        vext [3];
    logic [DW-1:0]      dneg;
    logic [DW-1:0]      nneg;
    logic               c_ready;

    // Stage D: full numerator, range check and first divider record.
    logic               d_valid_reg;
    pslt_cell_t         d_data_reg;
    pslt_cell_t         d_data_next;
    logic [79:0]        num_full [3];
    logic               d_ready;

    assign a_ready = !a_valid_reg || b_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign c_ready = !c_valid_reg || d_ready;
    assign d_ready = !d_valid_reg || out_ready;
    assign s_ready = a_ready;
    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

    // Distance at the product scale; the offset and radius are lifted by the normal scale.
    always_comb begin
        b_dist_next = DW'(a_np_reg[0]) + DW'(a_np_reg[1]) + DW'(a_np_reg[2])
                    + {{(DW-32-NORM_FRAC){a_off_reg[31]}}, a_off_reg, {NORM_FRAC{1'b0}}};
        b_den_next  = DW'(a_nv_reg[0]) + DW'(a_nv_reg[1]) + DW'(a_nv_reg[2]);
    end

    // Side tests and magnitudes for the divider.
    always_comb begin
        dneg = DW'(0) - b_dist_reg;
        nneg = DW'(0) - b_den_reg;
        c_dmag_next = b_dist_reg[DW-1] ? dneg[MW-1:0] : b_dist_reg[MW-1:0];
        c_den_next  = b_den_reg[DW-1] ? nneg[MW-1:0] : b_den_reg[MW-1:0];
        for (int i = 0; i < 3; i++) begin
            vext[i] = {b_v_reg[i][31], b_v_reg[i]};
            c_vmag_next[i] = b_v_reg[i][31] ? 32'(33'd0 - vext[i]) : b_v_reg[i];
        end
        case (b_mode_reg)
            MODE_POINT:  c_front_next = b_dist_reg > DW'(0);
            MODE_SPHERE: c_front_next = b_dist_reg >
                             $signed({{(DW-31-NORM_FRAC){1'b0}}, b_rad_reg,
                                      {NORM_FRAC{1'b0}}});
            default:     c_front_next = 1'b0;
        endcase
    end

    // Assemble the numerator and start the division.
    always_comb begin
        d_data_next          = '0;
        d_data_next.den      = c_den_reg;
        d_data_next.pnt      = c_p_reg;
        d_data_next.pos      = c_pos_reg;
        d_data_next.mode     = c_mode_reg;
        d_data_next.in_front = c_front_reg;
        d_data_next.par      = c_par_reg;
        for (int i = 0; i < 3; i++) begin
            num_full[i] = {c_phi_reg[i], 32'd0} + {16'd0, c_plo_reg[i]};
            d_data_next.ovf[i] = {1'b0, num_full[i][79:QBITS]} >= c_den_reg;
            d_data_next.rem[i] = {1'b0, num_full[i][79:QBITS]};
            d_data_next.num[i] = num_full[i][QBITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end

        if (a_ready && s_valid) begin
            a_mode_reg  <= s_payload.mode;
            a_rad_reg   <= s_payload.radius;
            a_off_reg   <= offset;
            a_p_reg[0]  <= s_payload.point_x;
            a_p_reg[1]  <= s_payload.point_y;
            a_p_reg[2]  <= s_payload.point_z;
            a_v_reg[0]  <= s_payload.dir_x;
            a_v_reg[1]  <= s_payload.dir_y;
            a_v_reg[2]  <= s_payload.dir_z;
            a_np_reg[0] <= nx * s_payload.point_x;
            a_np_reg[1] <= ny * s_payload.point_y;
            a_np_reg[2] <= nz * s_payload.point_z;
            a_nv_reg[0] <= nx * s_payload.dir_x;
            a_nv_reg[1] <= ny * s_payload.dir_y;
            a_nv_reg[2] <= nz * s_payload.dir_z;
        end

        if (b_ready && a_valid_reg) begin
            b_mode_reg <= a_mode_reg;
            b_rad_reg  <= a_rad_reg;
            b_p_reg    <= a_p_reg;
            b_v_reg    <= a_v_reg;
            b_dist_reg <= b_dist_next;
            b_den_reg  <= b_den_next;
        end

        if (c_ready && b_valid_reg) begin
            c_mode_reg  <= b_mode_reg;
            c_front_reg <= c_front_next;
            c_par_reg   <= (b_mode_reg == MODE_LINE) && (b_den_reg == DW'(0));
            c_den_reg   <= c_den_next;
            for (int i = 0; i < 3; i++) begin
                c_p_reg[i]   <= b_p_reg[i];
                c_pos_reg[i] <= b_v_reg[i][31] ^ b_dist_reg[DW-1] ^ b_den_reg[DW-1];
                c_plo_reg[i] <= c_vmag_next[i] * c_dmag_next[31:0];
                c_phi_reg[i] <= c_vmag_next[i] * c_dmag_next[MW-1:32];
            end
        end

        if (d_ready && c_valid_reg) begin
            d_data_reg <= d_data_next;
        end
    end

endmodule

// ----- design/pslt_back.sv -----
// Back stage: applies the quotient to the origin, saturates and holds the result.
// Depends on pslt_pkg.
module pslt_back
    import pslt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  pslt_cell_t in_data,
    output logic       m_valid,
    input  logic       m_ready,
    output pslt_out_t  m_payload
);

    logic        valid_reg;
    pslt_out_t   out_reg;
    pslt_out_t   out_next;
    logic [2:0]  clip;
    logic [31:0] hit [3];
    logic signed [34:0] sum [3];
    logic signed [34:0] pext [3];
    logic signed [34:0] qext [3];

    assign in_ready  = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_payload = out_reg;

    // Hit point per axis with saturation to the signed 32-bit range.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pext[i] = $signed({{3{in_data.pnt[i][31]}}, in_data.pnt[i]});
            qext[i] = $signed({2'b00, in_data.quo[i]});
            sum[i]  = in_data.pos[i] ? pext[i] + qext[i] : pext[i] - qext[i];
            clip[i] = 1'b0;
            if (in_data.ovf[i]) begin
                hit[i]  = in_data.pos[i] ? 32'h7FFF_FFFF : 32'h8000_0000;
                clip[i] = 1'b1;
            end else if (sum[i] > 35'sh0_7FFF_FFFF) begin
                hit[i]  = 32'h7FFF_FFFF;
                clip[i] = 1'b1;
            end else if (sum[i] < -35'sh0_8000_0000) begin
                hit[i]  = 32'h8000_0000;
                clip[i] = 1'b1;
            end else begin
                hit[i] = sum[i][31:0];
            end
        end
        out_next = '0;
        if (in_data.mode == MODE_POINT || in_data.mode == MODE_SPHERE) begin
            out_next.in_front = in_data.in_front;
        end else if (in_data.mode == MODE_LINE) begin
            if (in_data.par) begin
                out_next.parallel = 1'b1;
            end else begin
                out_next.hit_x   = hit[0];
                out_next.hit_y   = hit[1];
                out_next.hit_z   = hit[2];
                out_next.clipped = |clip;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- design/plane_side_test_and_line_intersect.sv -----
// Pipeline: 4 front stages, 33 divider cells and 1 output stage.
// Throughput: one request per cycle while the output is not stalled; every stage has its own valid bit and
// takes a new request whenever it is empty or its successor moves on.
// The divider chain retires one quotient bit per cell for each of the three axes.
// Reset (aresetn, synchronous, active low) empties the pipeline and loads the
// plane registers with normal (0, 0, 1.0) and offset 0.
module plane_side_test_and_line_intersect
    import pslt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pslt_in_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output pslt_out_t   m_payload,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;
    logic signed [31:0] off_reg;

    logic       chain_valid [QBITS+1];
    logic       chain_ready [QBITS+1];
    pslt_cell_t chain_data  [QBITS+1];

    assign cfg_ready = 1'b1;

    // Plane registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg  <= 16'sd0;
            ny_reg  <= 16'sd0;
            nz_reg  <= 16'sd16384;
            off_reg <= 32'sd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_NORMAL_X: nx_reg  <= cfg_data[15:0];
                CFG_NORMAL_Y: ny_reg  <= cfg_data[15:0];
                CFG_NORMAL_Z: nz_reg  <= cfg_data[15:0];
                CFG_OFFSET:   off_reg <= cfg_data;
                default:      off_reg <= off_reg;
            endcase
        end
    end

    pslt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .nx        (nx_reg),
        .ny        (ny_reg),
        .nz        (nz_reg),
        .offset    (off_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // Row of division cells, one quotient bit each.
    for (genvar k = 0; k < QBITS; k++) begin : g_cell
        pslt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    pslt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[QBITS]),
        .in_ready  (chain_ready[QBITS]),
        .in_data   (chain_data[QBITS]),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

`ifndef SYNTH
    // A parallel line carries no hit point, no clipping and no side result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.parallel) |->
            (!m_payload.clipped && !m_payload.in_front && m_payload.hit_x == 32'sd0
             && m_payload.hit_y == 32'sd0 && m_payload.hit_z == 32'sd0))
        else $error("parallel result carries other fields");

    // Side results and line results never appear together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.in_front) |-> (!m_payload.clipped && !m_payload.parallel))
        else $error("side result mixed with line result");

    // The pipeline is empty after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A held result stays unchanged until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("held result changed");
`endif

endmodule
